// ===== rtl/tw_tx_pkg.sv =====
// Package: shared types and sequencer states for the two-wire serial writer.
`default_nettype none
package tw_tx_pkg;

    // Input beat: one byte and its frame flags.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_frame;
        logic       last_of_frame;
    } t_in_beat;

    // Output beat: one pin write.
    typedef struct packed {
        logic clock_level;
        logic data_level;
        logic run_end;
    } t_out_beat;

    // Sequencer phases.
    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_START,
        SEQ_BIT,
        SEQ_ACK,
        SEQ_STOP
    } t_seq_state;

    // Classified queue entry: byte, first phase to run, stop request.
    typedef struct packed {
        logic [7:0] shift_byte;
        t_seq_state entry_state;
        logic       has_stop;
    } t_q_entry;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [2:0] BIT_LAST = 3'd7;

endpackage
`default_nettype wire

// ===== rtl/tw_tx_front.sv =====
// Front end: accepts input beats and classifies them into queue entries.
`default_nettype none
module tw_tx_front
    import tw_tx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_beat,
    output logic          o_q_valid,
    input  wire logic     i_q_ready,
    output t_q_entry      o_q_entry
);

    logic     r_valid;
    t_q_entry r_entry;
    logic     accept;

    assign o_in_ready = !r_valid || i_q_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_valid  = r_valid;
    assign o_q_entry  = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_q_ready) begin
            r_valid <= 1'b0;
        end
    end

    // A start condition opens the sequence when asked, else go straight to bits.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_entry.shift_byte  <= i_in_beat.data_byte;
            r_entry.entry_state <= i_in_beat.first_of_frame ? SEQ_START : SEQ_BIT;
            r_entry.has_stop    <= i_in_beat.last_of_frame;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tw_tx_queue.sv =====
// Queue: small FIFO of classified entries between front and back.
`default_nettype none
module tw_tx_queue
    import tw_tx_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push_valid,
    output logic          o_push_ready,
    input  wire t_q_entry i_push_entry,
    output logic          o_pop_valid,
    input  wire logic     i_pop,
    output t_q_entry      o_pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_q_entry           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/tw_tx_back.sv =====
// Back end: pin-write sequencer with registered output beat.
`default_nettype none
module tw_tx_back
    import tw_tx_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_valid,
    output logic          o_q_pop,
    input  wire t_q_entry i_q_entry,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_beat
);

    t_seq_state r_state, n_state;
    logic [1:0] r_sub, n_sub;
    logic [2:0] r_bit, n_bit;
    logic [7:0] r_shift, n_shift;
    logic       r_stop, n_stop;
    logic       r_clk, n_clk;
    logic       r_dat, n_dat;
    logic       r_out_valid, n_out_valid;
    t_out_beat  r_out_beat, n_out_beat;

    logic busy;
    logic advance;
    logic ending;
    logic pop;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;
    assign o_q_pop     = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= SEQ_IDLE;
            r_sub       <= '0;
            r_bit       <= '0;
            r_clk       <= 1'b1;
            r_dat       <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sub       <= n_sub;
            r_bit       <= n_bit;
            r_clk       <= n_clk;
            r_dat       <= n_dat;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift    <= n_shift;
        r_stop     <= n_stop;
        r_out_beat <= n_out_beat;
    end

    always_comb begin
        n_state     = r_state;
        n_sub       = r_sub;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_stop      = r_stop;
        n_clk       = r_clk;
        n_dat       = r_dat;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_beat  = r_out_beat;
        ending      = 1'b0;

        busy    = (r_state != SEQ_IDLE);
        advance = busy && (!r_out_valid || i_out_ready);

        if (advance) begin
            n_sub = r_sub + 1'b1;
            case (r_state)
                SEQ_START: begin
                    case (r_sub)
                        2'd0: n_dat = 1'b1;
                        2'd1: n_clk = 1'b1;
                        default: begin
                            n_dat   = 1'b0;
                            n_state = SEQ_BIT;
                            n_sub   = '0;
                        end
                    endcase
                end
                SEQ_BIT: begin
                    case (r_sub)
                        2'd0: n_clk = 1'b0;
                        2'd1: n_dat = |(r_shift & MSB_MASK);
                        default: begin
                            n_clk   = 1'b1;
                            n_shift = {r_shift[6:0], 1'b0};
                            n_bit   = r_bit + 1'b1;
                            n_sub   = '0;
                            if (r_bit == BIT_LAST) begin
                                n_state = SEQ_ACK;
                            end
                        end
                    endcase
                end
                SEQ_ACK: begin
                    // Acknowledge clock pulse; data is left alone, nothing sampled.
                    if (r_sub == 2'd0) begin
                        n_clk = 1'b0;
                    end else begin
                        n_clk = 1'b1;
                        n_sub = '0;
                        if (r_stop) begin
                            n_state = SEQ_STOP;
                        end else begin
                            ending = 1'b1;
                        end
                    end
                end
                SEQ_STOP: begin
                    case (r_sub)
                        2'd0: n_dat = 1'b0;
                        2'd1: n_clk = 1'b1;
                        default: begin
                            n_dat  = 1'b1;
                            n_sub  = '0;
                            ending = 1'b1;
                        end
                    endcase
                end
                default: begin
                    n_sub = r_sub;
                end
            endcase
            n_out_valid            = 1'b1;
            n_out_beat.clock_level = n_clk;
            n_out_beat.data_level  = n_dat;
            n_out_beat.run_end     = ending;
        end

        // Hand over to the next byte on the final write, or when idle.
        pop = i_q_valid && (!busy || ending);
        if (pop) begin
            n_state = i_q_entry.entry_state;
            n_shift = i_q_entry.shift_byte;
            n_stop  = i_q_entry.has_stop;
            n_sub   = '0;
            n_bit   = '0;
        end else if (ending) begin
            n_state = SEQ_IDLE;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/two_wire_display_serial_tx.sv =====
// Top level: bit-banged two-wire serial byte writer.
// Each input beat carries one byte plus first/last frame flags and expands into
// a run of pin writes, one output beat per write, giving clock and data levels
// after that write. A first byte is preceded by a start condition (data high,
// clock high, data low); the byte goes out MSB first as clock low, data set,
// clock high per bit; one unsampled acknowledge pulse follows (clock low, clock
// high); a last byte is followed by data low, clock high, data high. run_end
// marks the final write of each byte's run. Both lines idle high after reset.
// A byte yields 26 to 32 writes and the back-end sequencer emits one write per
// cycle when the output is not stalled; the next queued byte is loaded together
// with the previous run_end write. The front register and the QUEUE_DEPTH-entry
// queue let new bytes be taken while a run is in progress; an accepted byte
// passes the front register, queue and sequencer to its first registered write.
`default_nettype none
module two_wire_display_serial_tx
    import tw_tx_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_beat  i_in_beat,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_beat      o_out_beat
);

    // front -> queue
    logic     fq_valid;
    logic     fq_ready;
    t_q_entry fq_entry;

    // queue -> back
    logic     qb_valid;
    logic     qb_pop;
    t_q_entry qb_entry;

    tw_tx_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_q_valid  (fq_valid),
        .i_q_ready  (fq_ready),
        .o_q_entry  (fq_entry)
    );

    tw_tx_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_entry (fq_entry),
        .o_pop_valid  (qb_valid),
        .i_pop        (qb_pop),
        .o_pop_entry  (qb_entry)
    );

    // Sequencer holds the line levels across bytes and frames.
    tw_tx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (qb_valid),
        .o_q_pop     (qb_pop),
        .i_q_entry   (qb_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_two_wire_display_serial_tx.sv =====
// Testbench: two-wire serial writer, byte beats in, pin-write beats checked against a predictor.
`timescale 1ns / 100ps
module tb_two_wire_display_serial_tx
    import tw_tx_pkg::*;
();

    // ------------------------------------------------------------------
    // Pin-write predictor and scoreboard.
    // Keeps its own copy of the clock/data line levels and expands every
    // accepted byte beat into the ordered list of pin writes it should
    // cause. Output beats are checked in order against that list.
    // ------------------------------------------------------------------
    class pin_write_predictor;
        logic       held_clock;
        logic       held_data;
        t_out_beat  expected_writes[$];
        int         error_count;

        function new();
            held_clock  = 1'b1;   // bus idles high out of reset
            held_data   = 1'b1;
            error_count = 0;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        function void push_write();
            t_out_beat w;
            w.clock_level = held_clock;
            w.data_level  = held_data;
            w.run_end     = 1'b0;
            expected_writes.push_back(w);
        endfunction

        function void drive_clock(logic level);
            held_clock = level;
            push_write();
        endfunction

        function void drive_data(logic level);
            held_data = level;
            push_write();
        endfunction

        // Expand one accepted byte beat into its pin writes.
        function void note_byte(t_in_beat b);
            logic [7:0] shreg;
            t_out_beat  tail;
            shreg = b.data_byte;
            // start condition: data high, clock high, data low
            if (b.first_of_frame) begin
                drive_data(1'b1);
                drive_clock(1'b1);
                drive_data(1'b0);
            end
            // 8 bits, MSB first: clock low, data, clock high
            for (int k = 0; k < 8; k++) begin
                drive_clock(1'b0);
                drive_data(shreg[7]);
                drive_clock(1'b1);
                shreg = shreg << 1;
            end
            // ack pulse, data line untouched
            drive_clock(1'b0);
            drive_clock(1'b1);
            // stop: data low, clock high, data high
            if (b.last_of_frame) begin
                drive_data(1'b0);
                drive_clock(1'b1);
                drive_data(1'b1);
            end
            // last write of this byte's run carries run_end
            tail = expected_writes.pop_back();
            tail.run_end = 1'b1;
            expected_writes.push_back(tail);
        endfunction

        // Compare one accepted output beat against the oldest expectation.
        function void check_write(t_out_beat got);
            t_out_beat exp_w;
            if (expected_writes.size() == 0) begin
                error_count++;
                if (error_count <= 100)
                    $error("pin write with nothing expected: clk=%0b dat=%0b end=%0b",
                           got.clock_level, got.data_level, got.run_end);
                return;
            end
            exp_w = expected_writes.pop_front();
            if (got.clock_level !== exp_w.clock_level) begin
                error_count++;
                if (error_count <= 100)
                    $error("clock_level: expected %0b, got %0b",
                           exp_w.clock_level, got.clock_level);
            end
            if (got.data_level !== exp_w.data_level) begin
                error_count++;
                if (error_count <= 100)
                    $error("data_level: expected %0b, got %0b",
                           exp_w.data_level, got.data_level);
            end
            if (got.run_end !== exp_w.run_end) begin
                error_count++;
                if (error_count <= 100)
                    $error("run_end: expected %0b, got %0b", exp_w.run_end, got.run_end);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_beat  i_in_beat;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_beat o_out_beat;

    two_wire_display_serial_tx uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

    pin_write_predictor board;

    // Percent chance, per cycle, that each side sits idle.
    int byte_idle_pct;
    int write_stall_pct;

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop: far beyond the slowest legal run.
    initial begin
        #2000000;
        $display("tb_two_wire_display_serial_tx: done, errors");
        $finish;
    end

    // Receiver backpressure, re-rolled every falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= write_stall_pct);
    end

    // Output monitor: every accepted pin-write beat is checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_write(o_out_beat);
    end

    // ------------------------------------------------------------------
    // Byte driver. Optional idle gap first (valid low), then present the
    // beat at a falling edge and hold it until the handshake at a rising
    // edge. Valid stays high across back-to-back beats with no gap.
    // ------------------------------------------------------------------
    task automatic send_byte(input t_in_beat b);
        while ($urandom_range(0, 99) < byte_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        board.note_byte(b);
    endtask

    task automatic send_fields(input logic [7:0] val, input logic first, input logic last);
        t_in_beat b;
        b.data_byte      = val;
        b.first_of_frame = first;
        b.last_of_frame  = last;
        send_byte(b);
    endtask

    // Sender goes quiet until every predicted pin write has come out.
    task automatic drain_writes();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge i_clk);
    endtask

    // Mostly well-formed frames (start on the first byte, stop on the last)
    // with random content; the rest are bytes with random flags, which
    // covers missing starts, repeated starts and stray stops.
    task automatic send_random(input int n_bytes);
        int sent;
        int frame_len;
        sent = 0;
        while (sent < n_bytes) begin
            if ($urandom_range(0, 99) < 85) begin
                frame_len = $urandom_range(1, 6);
                for (int j = 0; j < frame_len; j++)
                    send_fields(8'($urandom_range(0, 255)), j == 0, j == frame_len - 1);
                sent += frame_len;
            end else begin
                send_fields(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        board           = new();
        byte_idle_pct   = 11;
        write_stall_pct = 76;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_in_beat       = '0;
        i_out_ready     = 1'b0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, all flag combos, frames out of order.
        send_fields(8'h00, 1'b1, 1'b0);   // plain frame open
        send_fields(8'hFF, 1'b0, 1'b0);
        send_fields(8'h80, 1'b0, 1'b1);   // close
        send_fields(8'h01, 1'b1, 1'b1);   // single-byte frame, 32 writes
        send_fields(8'hAA, 1'b0, 1'b0);   // byte with no start before it
        send_fields(8'h55, 1'b1, 1'b0);
        send_fields(8'hC3, 1'b1, 1'b0);   // start while frame still open
        send_fields(8'h3C, 1'b0, 1'b1);
        send_fields(8'h7F, 1'b0, 1'b1);   // stop with no frame open
        send_fields(8'hFE, 1'b1, 1'b1);

        // Hold off the sender until the pipe is empty, then restart.
        drain_writes();

        // Sender light, receiver heavy stalls.
        send_random(87);
        // Swap: sender mostly idle, receiver mostly ready.
        byte_idle_pct   = 76;
        write_stall_pct = 11;
        send_random(87);
        // Full speed on both sides.
        byte_idle_pct   = 0;
        write_stall_pct = 0;
        send_random(86);

        drain_writes();
        // Give any stray extra writes time to show up.
        repeat (64) @(posedge i_clk);

        if (board.error_count == 0 && board.pending() == 0) begin
            $display("tb_two_wire_display_serial_tx: done, clean");
        end else begin
            $display("tb_two_wire_display_serial_tx: done, errors");
        end
        $finish;
    end

endmodule
